>>> rtl/lfr_pkg.sv
// shared types, constants and helpers for the lagged fibonacci rng with shuffle
// no dependencies
`default_nettype none

package lfr_pkg;

  localparam int WORD_W          = 32;
  localparam int OUT_W           = 31;
  localparam int RESULT_BITS_DEF = 31;

  localparam int LAG_LEN     = 55;
  localparam int LAG_IDX_W   = 6;
  localparam int SHORT_START = 23;
  localparam int LONG_START  = 54;

  localparam int SHUF_LEN    = 256;
  localparam int SHUF_ADDR_W = 8;

  // discarded words, table fill words and the held word
  localparam int MIX_WORDS = 2 * SHUF_LEN + 1;
  localparam int MIX_CNT_W = $clog2(MIX_WORDS + 1);

  localparam logic FUNC_RESEED = 1'b0;
  localparam logic FUNC_DRAW   = 1'b1;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [LAG_IDX_W-1:0]   lag_idx_t;
  typedef logic [SHUF_ADDR_W-1:0] shuf_addr_t;

  typedef struct packed {
    logic     load;
    lag_idx_t load_addr;
    word_t    load_data;
    logic     step;
    logic     reset_idx;
  } lag_ctl_t;

  // decrement with wrap, out of range indices restart at the top
  function automatic lag_idx_t step_down(input lag_idx_t idx);
    if (idx == '0 || idx >= lag_idx_t'(LAG_LEN)) begin
      return lag_idx_t'(LAG_LEN - 1);
    end
    return idx - lag_idx_t'(1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/lfr_if.sv
// valid/ready channel interfaces for the request and result transactions
// no dependencies
`default_nettype none

interface lfr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] seed;

  modport source (output valid, output func, output seed, input ready);
  modport sink (input valid, input func, input seed, output ready);
endinterface

interface lfr_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

`default_nettype wire

>>> rtl/lfr_lag_gen.sv
// 55 word lag memory with the two lag indices, makes one fresh word per step
// depends on lfr_pkg
`default_nettype none

module lfr_lag_gen
  import lfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lag_ctl_t ctl,
  output logic          fresh_valid,
  output word_t         fresh_word
);

  word_t    mem [LAG_LEN];
  word_t    q_short;
  word_t    q_long;
  lag_idx_t short_idx;
  lag_idx_t long_idx;
  lag_idx_t short_idx_next;
  lag_idx_t long_idx_next;
  logic     pend;

  assign short_idx_next = step_down(short_idx);
  assign long_idx_next  = step_down(long_idx);

  assign fresh_word  = q_short + q_long;
  assign fresh_valid = pend;

  // load and writeback never overlap
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[ctl.load_addr] <= ctl.load_data;
    end else if (pend) begin
      mem[long_idx] <= fresh_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      q_short <= mem[short_idx_next];
      q_long  <= mem[long_idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      short_idx <= lag_idx_t'(SHORT_START);
      long_idx  <= lag_idx_t'(LONG_START);
    end else begin
      pend <= ctl.step;
      if (ctl.reset_idx) begin
        short_idx <= lag_idx_t'(SHORT_START);
        long_idx  <= lag_idx_t'(LONG_START);
      end else if (ctl.step) begin
        short_idx <= short_idx_next;
        long_idx  <= long_idx_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lfr_shuf_mem.sv
// 256 word shuffle table, one write port and one registered read port
// depends on lfr_pkg
`default_nettype none

module lfr_shuf_mem
  import lfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire shuf_addr_t wr_addr,
  input  wire word_t      wr_data,
  input  wire logic       rd_en,
  input  wire shuf_addr_t rd_addr,
  output word_t           rd_data
);

  word_t mem [SHUF_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lagged_fibonacci_shuffled_rng.sv
// Additive lagged fibonacci generator (lags 24 and 55, 32-bit words) whose
// output runs through a 256-entry shuffle table. A draw transaction loads one
// 31-bit value from the registered shuffle read into the result register, and
// no new request is taken before the draw is done: the shuffle entry read and
// the lag step run side by side, each behind one registered memory read, and
// the next cycle writes both memories back. While the result register still
// holds an unaccepted value, a finished draw waits and ready stays low.
// A reseed transaction returns nothing and keeps ready low while it loads the
// 55 words of the lag memory and then runs 513 lag steps, one per cycle
// through the lag memory's two read ports, and waits for the last sum. After
// reset the same pass runs with seed 0 before the first transaction is taken.
// depends on lfr_pkg, lfr_if, lfr_lag_gen and lfr_shuf_mem
`default_nettype none

module lagged_fibonacci_shuffled_rng
  import lfr_pkg::*;
#(
  parameter int RESULT_BITS = RESULT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lfr_in_if.sink     req,
  lfr_out_if.source  rsp
);

  localparam word_t RESULT_MASK = (RESULT_BITS >= WORD_W) ? '1 :
                                  word_t'((64'd1 << RESULT_BITS) - 64'd1);

  localparam logic [2:0] ST_FILL = 3'd0;
  localparam logic [2:0] ST_MIX  = 3'd1;
  localparam logic [2:0] ST_IDLE = 3'd2;
  localparam logic [2:0] ST_DRAW = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]           state;
  word_t                seed_q;
  word_t                fib_a;
  word_t                fib_b;
  lag_idx_t             fill_k;
  logic [MIX_CNT_W-1:0] issued;
  logic [MIX_CNT_W-1:0] recv;
  word_t                held;
  shuf_addr_t           draw_addr;
  logic                 out_valid;
  logic [OUT_W-1:0]     out_value;

  logic       accept;
  logic       out_free;
  logic       out_load;
  word_t      out_word;
  lag_ctl_t   lag_ctl;
  logic       fresh_valid;
  word_t      fresh_word;
  logic       shuf_wr_en;
  shuf_addr_t shuf_wr_addr;
  word_t      shuf_q;

  assign req.ready        = (state == ST_IDLE);
  assign accept           = req.valid && req.ready;
  assign out_free         = !out_valid || rsp.ready;
  assign out_load         = ((state == ST_DRAW) || (state == ST_HOLD)) && out_free;
  assign out_word         = (state == ST_DRAW) ? shuf_q : held;
  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;

  always_comb begin
    lag_ctl.load      = (state == ST_FILL);
    lag_ctl.load_addr = fill_k;
    if (fill_k == lag_idx_t'(0)) begin
      lag_ctl.load_data = word_t'(1);
    end else if (fill_k == lag_idx_t'(1)) begin
      lag_ctl.load_data = seed_q;
    end else begin
      lag_ctl.load_data = fib_a + fib_b;
    end
    lag_ctl.step      = ((state == ST_MIX) && (issued != MIX_CNT_W'(MIX_WORDS))) ||
                        (accept && req.func == FUNC_DRAW);
    lag_ctl.reset_idx = accept && req.func == FUNC_RESEED;
  end

  // table fill runs from the top entry down
  always_comb begin
    shuf_wr_en   = ((state == ST_MIX) && fresh_valid &&
                    recv >= MIX_CNT_W'(SHUF_LEN) && recv < MIX_CNT_W'(2 * SHUF_LEN)) ||
                   (state == ST_DRAW);
    shuf_wr_addr = (state == ST_DRAW) ? draw_addr :
                   shuf_addr_t'(SHUF_LEN - 1) - recv[SHUF_ADDR_W-1:0];
  end

  lfr_lag_gen u_lag_gen (
    .clk         (clk),
    .rst         (rst),
    .ctl         (lag_ctl),
    .fresh_valid (fresh_valid),
    .fresh_word  (fresh_word)
  );

  lfr_shuf_mem u_shuf_mem (
    .clk     (clk),
    .wr_en   (shuf_wr_en),
    .wr_addr (shuf_wr_addr),
    .wr_data (fresh_word),
    .rd_en   (accept && req.func == FUNC_DRAW),
    .rd_addr (held[WORD_W-1 -: SHUF_ADDR_W]),
    .rd_data (shuf_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= OUT_W'(out_word & RESULT_MASK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      seed_q    <= '0;
      fill_k    <= '0;
      issued    <= '0;
      recv      <= '0;
    end else begin
      unique case (state)
        ST_FILL: begin
          fib_a <= fib_b;
          fib_b <= lag_ctl.load_data;
          if (fill_k == lag_idx_t'(LAG_LEN - 1)) begin
            state  <= ST_MIX;
            issued <= '0;
            recv   <= '0;
          end else begin
            fill_k <= fill_k + lag_idx_t'(1);
          end
        end
        ST_MIX: begin
          if (lag_ctl.step) begin
            issued <= issued + MIX_CNT_W'(1);
          end
          if (fresh_valid) begin
            recv <= recv + MIX_CNT_W'(1);
            if (recv == MIX_CNT_W'(MIX_WORDS - 1)) begin
              held  <= fresh_word;
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.func == FUNC_DRAW) begin
              draw_addr <= held[WORD_W-1 -: SHUF_ADDR_W];
              state     <= ST_DRAW;
            end else begin
              seed_q <= req.seed;
              fill_k <= '0;
              state  <= ST_FILL;
            end
          end
        end
        ST_DRAW: begin
          held <= shuf_q;
          if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
